// ===== rtl/npec_pkg.sv =====
// Shared types, constants and field layouts of the near-plane edge clipper.
// Depends on nothing; every other file of the block imports it.
package npec_pkg;

    // Trigonometry resolution and angle constants (1/64 degree units).
    localparam int unsigned TRIG_BITS_DEF = 16;
    localparam int unsigned TURN          = 23040;
    localparam int unsigned QUARTER       = 5760;
    localparam longint unsigned RAD_SCALE = 64'd299845282;
    localparam int unsigned Q_ONE         = 32768;

    // Divisors of the Horner steps of the sine series, innermost first.
    localparam int unsigned HORNER_STEPS = 5;
    localparam int unsigned HORNER_DIV [HORNER_STEPS] = '{110, 72, 42, 20, 6};

    // Cycles the forward vector needs to settle after a register write.
    localparam int unsigned SETTLE_CYCLES = 32;
    localparam int unsigned SETTLE_W      = $clog2(SETTLE_CYCLES + 1);

    // Fraction divider widths.
    localparam int unsigned DEN_W = 38;
    localparam int unsigned REM_W = 54;
    localparam int unsigned QUO_W = 16;

    // Stream widths.
    localparam int unsigned IN_TDATA_W  = 192;
    localparam int unsigned OUT_TDATA_W = 184;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 32;

    // Register indexes of the configuration channel.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EYE_X  = 3'd0,
        REG_EYE_Y  = 3'd1,
        REG_EYE_Z  = 3'd2,
        REG_YAW    = 3'd3,
        REG_PITCH  = 3'd4,
        REG_NEAR   = 3'd5
    } cfg_reg_t;

    // View forward vector, Q1.15 components.
    typedef struct packed {
        logic signed [16:0] fx;
        logic signed [16:0] fy;
        logic signed [16:0] fz;
    } fwd_t;

    // The two endpoints of one edge.
    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
    } pts_t;

    // Classification of the edge fraction.
    typedef struct packed {
        logic degen;
        logic under;
        logic over;
    } flags_t;

    // Everything that rides alongside the divider.
    typedef struct packed {
        pts_t               pts;
        flags_t             flags;
        logic signed [31:0] hd;
        logic signed [31:0] sd;
    } side_t;

endpackage

// ===== rtl/near_plane_edge_clipper_core.sv =====
// Near-plane edge clipper: top level with register file, depth stages and cut stages.
// Depends on npec_pkg, npec_trig, npec_qsine and npec_div.
//
// Usage:
// An edge enters on the s_ channel as a hidden endpoint and a visible endpoint and
// leaves on the m_ channel as the cut point, the fraction along the edge, both view
// depths and two flags. The cfg_ channel writes the eye position, yaw, pitch and near
// distance; it is always ready and should only be used while no edge is in flight.
// Throughput is one edge per cycle while the receiver keeps up and the forward vector
// has settled. An edge passes 22 register stages before m_tvalid rises: four depth
// stages, sixteen divider stages (one quotient bit each) and two cut stages.
// The forward vector comes from a free-running trigonometry pipeline; after reset and
// after every register write s_tready stays low while it settles.
// When the receiver stalls, results pile up in the pipeline stages, empty stages are
// still filled from the input, and s_tready falls only once every stage is full.
// Reset clears all valid bits and loads the register defaults.
module near_plane_edge_clipper_core
    import npec_pkg::*;
#(
    parameter int unsigned TRIG_BITS = TRIG_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Edge input: hidden_x, hidden_y, hidden_z, shown_x, shown_y, shown_z.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,
    // Result: cut_x, cut_y, cut_z, cut_fraction, hidden_depth, shown_depth,
    // degenerate, out_of_span, zero padding.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // Register writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Register file.
    logic signed [31:0] eye_x_reg, eye_y_reg, eye_z_reg;
    logic [14:0]        yaw_reg;
    logic signed [13:0] pitch_reg;
    logic [30:0]        near_reg;
    logic [SETTLE_W-1:0] settle_reg;
    logic               cfg_fire;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eye_x_reg  <= '0;
            eye_y_reg  <= '0;
            eye_z_reg  <= '0;
            yaw_reg    <= '0;
            pitch_reg  <= '0;
            near_reg   <= 31'd16384;
            settle_reg <= SETTLE_W'(SETTLE_CYCLES);
        end
        else
        begin
            if (cfg_fire)
            begin
                settle_reg <= SETTLE_W'(SETTLE_CYCLES);
                unique case (cfg_index)
                    REG_EYE_X: eye_x_reg <= $signed(cfg_data);
                    REG_EYE_Y: eye_y_reg <= $signed(cfg_data);
                    REG_EYE_Z: eye_z_reg <= $signed(cfg_data);
                    REG_YAW:   yaw_reg   <= cfg_data[14:0];
                    REG_PITCH: pitch_reg <= $signed(cfg_data[13:0]);
                    REG_NEAR:  near_reg  <= cfg_data[30:0];
                    default:   ;
                endcase
            end
            else if (settle_reg != '0)
                settle_reg <= settle_reg - SETTLE_W'(1);
        end
    end

    // Forward vector.
    fwd_t fwd;

    npec_trig #(.TRIG_BITS(TRIG_BITS)) u_trig
    (
        .clk   (clk),
        .yaw   (yaw_reg),
        .pitch (pitch_reg),
        .fwd   (fwd)
    );

    // Handshake chain: a stage loads when it is empty or its content moves on.
    logic v0_reg, v1_reg, v2_reg, v3_reg, vb0_reg, vb1_reg;
    logic rdy0, rdy1, rdy2, rdy3, rdyb0, rdyb1;
    logic div_in_ready, div_out_valid;
    logic in_fire;

    assign rdyb1    = !vb1_reg || m_tready;
    assign rdyb0    = !vb0_reg || rdyb1;
    assign rdy3     = !v3_reg || div_in_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_tready = rdy0 && (settle_reg == '0);
    assign in_fire  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg  <= 1'b0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            vb0_reg <= 1'b0;
            vb1_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)  v0_reg  <= in_fire;
            if (rdy1)  v1_reg  <= v0_reg;
            if (rdy2)  v2_reg  <= v1_reg;
            if (rdy3)  v3_reg  <= v2_reg;
            if (rdyb0) vb0_reg <= div_out_valid;
            if (rdyb1) vb1_reg <= vb0_reg;
        end
    end

    // Stage 0: endpoint minus eye.
    pts_t pts_in, pts0_reg, pts1_reg, pts2_reg;
    logic signed [32:0] da0_reg [3];
    logic signed [32:0] db0_reg [3];
    logic signed [31:0] eye [3];

    assign pts_in = {s_tdata[31:0], s_tdata[63:32], s_tdata[95:64],
                     s_tdata[127:96], s_tdata[159:128], s_tdata[191:160]};
    assign eye[0] = eye_x_reg;
    assign eye[1] = eye_y_reg;
    assign eye[2] = eye_z_reg;

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            pts0_reg   <= pts_in;
            da0_reg[0] <= 33'(pts_in.ax) - 33'(eye[0]);
            da0_reg[1] <= 33'(pts_in.ay) - 33'(eye[1]);
            da0_reg[2] <= 33'(pts_in.az) - 33'(eye[2]);
            db0_reg[0] <= 33'(pts_in.bx) - 33'(eye[0]);
            db0_reg[1] <= 33'(pts_in.by) - 33'(eye[1]);
            db0_reg[2] <= 33'(pts_in.bz) - 33'(eye[2]);
        end
    end

    // Stage 1: products with the forward vector.
    logic signed [49:0] pa1_reg [3];
    logic signed [49:0] pb1_reg [3];
    logic signed [16:0] fv [3];

    assign fv[0] = fwd.fx;
    assign fv[1] = fwd.fy;
    assign fv[2] = fwd.fz;

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            pts1_reg <= pts0_reg;
            for (int i = 0; i < 3; i++)
            begin
                pa1_reg[i] <= da0_reg[i] * fv[i];
                pb1_reg[i] <= db0_reg[i] * fv[i];
            end
        end
    end

    // Stage 2: depth sums rounded to Q16.16.
    logic signed [51:0] sa, sb;
    logic signed [36:0] dpa2_reg, dpb2_reg;

    assign sa = 52'(pa1_reg[0]) + 52'(pa1_reg[1]) + 52'(pa1_reg[2]) + 52'sd16384;
    assign sb = 52'(pb1_reg[0]) + 52'(pb1_reg[1]) + 52'(pb1_reg[2]) + 52'sd16384;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            pts2_reg <= pts1_reg;
            dpa2_reg <= 37'(sa >>> 15);
            dpb2_reg <= 37'(sb >>> 15);
        end
    end

    // Stage 3: numerator, denominator, classification and saturated depths.
    logic signed [37:0] nm, dn, numf, denf;
    flags_t             fl;
    side_t              side3_reg;
    logic [DEN_W-1:0]   den3_reg;
    logic [REM_W-1:0]   rem3_reg;

    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -37'sd2147483648)
            r = 32'sh80000000;
        else
            r = 32'(v);
        return r;
    endfunction

    assign nm = 38'(dpa2_reg) - 38'($signed({1'b0, near_reg}));
    assign dn = 38'(dpa2_reg) - 38'(dpb2_reg);

    always_comb
    begin
        numf     = dn[37] ? -nm : nm;
        denf     = dn[37] ? -dn : dn;
        fl.degen = (dn == '0);
        fl.under = !fl.degen && numf[37];
        fl.over  = !fl.degen && !numf[37] && (numf > denf);
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            side3_reg.pts   <= pts2_reg;
            side3_reg.flags <= fl;
            side3_reg.hd    <= sat32(dpa2_reg);
            side3_reg.sd    <= sat32(dpb2_reg);
            den3_reg        <= DEN_W'(denf);
            rem3_reg        <= (REM_W'(numf) << 15) + REM_W'(denf >>> 1);
        end
    end

    // Fraction divider.
    logic [QUO_W-1:0] quo;
    side_t            side_d;

    npec_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v3_reg),
        .in_ready  (div_in_ready),
        .in_den    (den3_reg),
        .in_rem    (rem3_reg),
        .in_side   (side3_reg),
        .out_valid (div_out_valid),
        .out_ready (rdyb0),
        .out_quo   (quo),
        .out_side  (side_d)
    );

    // Cut stage 0: choose the fraction and scale the edge vector.
    logic [15:0]        u;
    logic signed [32:0] dx, dy, dz;
    logic signed [49:0] ox0_reg, oy0_reg, oz0_reg;
    side_t              sideb0_reg;
    logic [15:0]        ub0_reg;

    always_comb
    begin
        priority if (side_d.flags.degen || side_d.flags.under)
            u = '0;
        else if (side_d.flags.over)
            u = 16'(Q_ONE);
        else
            u = quo;
    end

    assign dx = 33'(side_d.pts.bx) - 33'(side_d.pts.ax);
    assign dy = 33'(side_d.pts.by) - 33'(side_d.pts.ay);
    assign dz = 33'(side_d.pts.bz) - 33'(side_d.pts.az);

    always_ff @(posedge clk)
    begin
        if (rdyb0)
        begin
            sideb0_reg <= side_d;
            ub0_reg    <= u;
            ox0_reg    <= dx * $signed({1'b0, u});
            oy0_reg    <= dy * $signed({1'b0, u});
            oz0_reg    <= dz * $signed({1'b0, u});
        end
    end

    // Cut stage 1: round the offsets and form the output register.
    logic signed [49:0] rx, ry, rz;
    logic [31:0]        cut_x_reg, cut_y_reg, cut_z_reg;
    logic [15:0]        frac_reg;
    logic [31:0]        hd_reg, sd_reg;
    logic               degen_reg, oos_reg;

    assign rx = (ox0_reg + 50'sd16384) >>> 15;
    assign ry = (oy0_reg + 50'sd16384) >>> 15;
    assign rz = (oz0_reg + 50'sd16384) >>> 15;

    always_ff @(posedge clk)
    begin
        if (rdyb1)
        begin
            cut_x_reg <= 32'(sideb0_reg.pts.ax) + rx[31:0];
            cut_y_reg <= 32'(sideb0_reg.pts.ay) + ry[31:0];
            cut_z_reg <= 32'(sideb0_reg.pts.az) + rz[31:0];
            frac_reg  <= ub0_reg;
            hd_reg    <= sideb0_reg.hd;
            sd_reg    <= sideb0_reg.sd;
            degen_reg <= sideb0_reg.flags.degen;
            oos_reg   <= sideb0_reg.flags.under || sideb0_reg.flags.over;
        end
    end

    assign m_tvalid = vb1_reg;
    assign m_tdata  = {6'b0, oos_reg, degen_reg, sd_reg, hd_reg, frac_reg,
                       cut_z_reg, cut_y_reg, cut_x_reg};

endmodule

// ===== rtl/npec_qsine.sv =====
// Quarter-turn sine in Q1.15 by a pipelined Horner evaluation of the Taylor series.
// Depends on npec_pkg. Free-running: the output settles once the angle is stable.
module npec_qsine
    import npec_pkg::*;
#(
    parameter int unsigned TRIG_BITS = TRIG_BITS_DEF
)
(
    input  logic        clk,
    input  logic [12:0] angle,
    output logic [15:0] sine
);

    localparam int unsigned XW  = TRIG_BITS + 1;
    localparam int unsigned W   = TRIG_BITS + 3;
    localparam int unsigned S   = W + 7;
    localparam longint unsigned ONE = 64'd1 << TRIG_BITS;
    localparam longint unsigned RND = 64'd1 << (39 - TRIG_BITS);

    logic [XW-1:0]     x_reg;
    logic [W-1:0]      x2_reg;
    logic [W-1:0]      m_reg  [HORNER_STEPS];
    logic [W+S-1:0]    pr_reg [HORNER_STEPS];
    logic [XW-1:0]     p_reg  [HORNER_STEPS];
    logic [TRIG_BITS+1:0] q_reg;
    logic [15:0]       s_reg;

    logic [42:0]       xs;
    logic [2*XW-1:0]   xx;
    logic [2*XW-1:0]   qq;
    logic [TRIG_BITS+16:0] sc;
    logic [TRIG_BITS+16:0] sv;

    // Angle to radians and its square.
    assign xs = 43'(angle) * 43'(RAD_SCALE) + 43'(RND);
    assign xx = (2*XW)'(x_reg) * (2*XW)'(x_reg);

    always_ff @(posedge clk)
    begin
        x_reg  <= XW'(xs >> (40 - TRIG_BITS));
        x2_reg <= W'(xx >> TRIG_BITS);
    end

    // Horner steps: multiply, divide by the series constant, subtract from one.
    for (genvar j = 0; j < HORNER_STEPS; j++)
    begin : g_step
        localparam int unsigned D = HORNER_DIV[j];
        localparam longint unsigned MULV = ((64'd1 << S) + D - 1) / D;

        if (j == 0)
        begin : g_first
            always_ff @(posedge clk)
            begin
                m_reg[j] <= x2_reg;
            end
        end
        else
        begin : g_rest
            logic [W+XW-1:0] mp;

            assign mp = (W+XW)'(x2_reg) * (W+XW)'(p_reg[j-1]);
            always_ff @(posedge clk)
            begin
                m_reg[j] <= W'(mp >> TRIG_BITS);
            end
        end

        always_ff @(posedge clk)
        begin
            pr_reg[j] <= (W+S)'(m_reg[j]) * (W+S)'(MULV);
            p_reg[j]  <= XW'(ONE) - XW'(pr_reg[j] >> S);
        end
    end

    // Final multiply by x and rounding to Q1.15.
    assign qq = (2*XW)'(x_reg) * (2*XW)'(p_reg[HORNER_STEPS-1]);
    assign sc = ((TRIG_BITS+17)'(q_reg) << 15) + (TRIG_BITS+17)'(ONE >> 1);
    assign sv = sc >> TRIG_BITS;

    always_ff @(posedge clk)
    begin
        q_reg <= (TRIG_BITS+2)'(qq >> TRIG_BITS);
        s_reg <= (sv > (TRIG_BITS+17)'(Q_ONE)) ? 16'(Q_ONE) : 16'(sv);
    end

    assign sine = s_reg;

endmodule

// ===== rtl/npec_trig.sv =====
// Forward vector of the view from the yaw and pitch registers.
// Depends on npec_pkg and npec_qsine. Free-running pipeline of about 23 stages.
module npec_trig
    import npec_pkg::*;
#(
    parameter int unsigned TRIG_BITS = TRIG_BITS_DEF
)
(
    input  logic               clk,
    input  logic [14:0]        yaw,
    input  logic signed [13:0] pitch,
    output fwd_t               fwd
);

    logic [14:0] ya, pa;
    logic [15:0] pw;
    logic [1:0]  yq, pq;
    logic [12:0] yr, pr;
    logic [1:0]  yq_reg, pq_reg;
    logic [12:0] yr_reg, yc_reg, pr_reg, pc_reg;
    logic [15:0] ys, yc, ps, pc;
    logic signed [16:0] sy_reg, cy_reg, sp_reg, cp_reg;
    logic signed [16:0] sy, cy, sp, cp;
    logic signed [33:0] pyc_reg, pcc_reg;
    logic signed [34:0] tx, ty;
    fwd_t fwd_reg;

    // Reduce both angles to one turn and split off the quadrant.
    assign ya = (yaw >= 15'(TURN)) ? 15'(yaw - 15'(TURN)) : yaw;
    assign pw = 16'($signed({{2{pitch[13]}}, pitch}) + 16'sd23040);
    assign pa = pitch[13] ? pw[14:0] : {1'b0, pitch};

    always_comb
    begin
        priority if (ya < 15'(QUARTER))     begin yq = 2'd0; yr = 13'(ya); end
        else if (ya < 15'(2 * QUARTER))     begin yq = 2'd1; yr = 13'(ya - 15'(QUARTER)); end
        else if (ya < 15'(3 * QUARTER))     begin yq = 2'd2; yr = 13'(ya - 15'(2 * QUARTER)); end
        else                                begin yq = 2'd3; yr = 13'(ya - 15'(3 * QUARTER)); end
        priority if (pa < 15'(QUARTER))     begin pq = 2'd0; pr = 13'(pa); end
        else if (pa < 15'(2 * QUARTER))     begin pq = 2'd1; pr = 13'(pa - 15'(QUARTER)); end
        else if (pa < 15'(3 * QUARTER))     begin pq = 2'd2; pr = 13'(pa - 15'(2 * QUARTER)); end
        else                                begin pq = 2'd3; pr = 13'(pa - 15'(3 * QUARTER)); end
    end

    always_ff @(posedge clk)
    begin
        yq_reg <= yq;
        pq_reg <= pq;
        yr_reg <= yr;
        yc_reg <= 13'(QUARTER) - yr;
        pr_reg <= pr;
        pc_reg <= 13'(QUARTER) - pr;
    end

    // Sine and cosine of the remainders.
    npec_qsine #(.TRIG_BITS(TRIG_BITS)) u_ys (.clk(clk), .angle(yr_reg), .sine(ys));
    npec_qsine #(.TRIG_BITS(TRIG_BITS)) u_yc (.clk(clk), .angle(yc_reg), .sine(yc));
    npec_qsine #(.TRIG_BITS(TRIG_BITS)) u_ps (.clk(clk), .angle(pr_reg), .sine(ps));
    npec_qsine #(.TRIG_BITS(TRIG_BITS)) u_pc (.clk(clk), .angle(pc_reg), .sine(pc));

    // Quadrant symmetry.
    always_comb
    begin
        unique case (yq_reg)
            2'd0: begin sy =  $signed({1'b0, ys}); cy =  $signed({1'b0, yc}); end
            2'd1: begin sy =  $signed({1'b0, yc}); cy = -$signed({1'b0, ys}); end
            2'd2: begin sy = -$signed({1'b0, ys}); cy = -$signed({1'b0, yc}); end
            default: begin sy = -$signed({1'b0, yc}); cy = $signed({1'b0, ys}); end
        endcase
        unique case (pq_reg)
            2'd0: begin sp =  $signed({1'b0, ps}); cp =  $signed({1'b0, pc}); end
            2'd1: begin sp =  $signed({1'b0, pc}); cp = -$signed({1'b0, ps}); end
            2'd2: begin sp = -$signed({1'b0, ps}); cp = -$signed({1'b0, pc}); end
            default: begin sp = -$signed({1'b0, pc}); cp = $signed({1'b0, ps}); end
        endcase
    end

    // Horizontal components are products rounded back to Q1.15.
    assign tx = 35'sd16384 - 35'(pyc_reg);
    assign ty = 35'(pcc_reg) + 35'sd16384;

    always_ff @(posedge clk)
    begin
        sy_reg     <= sy;
        cy_reg     <= cy;
        sp_reg     <= sp;
        cp_reg     <= cp;
        pyc_reg    <= sy_reg * cp_reg;
        pcc_reg    <= cy_reg * cp_reg;
        fwd_reg.fx <= 17'(tx >>> 15);
        fwd_reg.fy <= 17'(ty >>> 15);
        fwd_reg.fz <= sp_reg;
    end

    assign fwd = fwd_reg;

endmodule

// ===== rtl/npec_div.sv =====
// Pipelined restoring divider for the edge fraction, one quotient bit per stage.
// Depends on npec_pkg. Stream handshake on both sides, side payload carried along.
module npec_div
    import npec_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [DEN_W-1:0] in_den,
    input  logic [REM_W-1:0] in_rem,
    input  side_t            in_side,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [QUO_W-1:0] out_quo,
    output side_t            out_side
);

    logic [QUO_W-1:0] v_reg;
    logic [DEN_W-1:0] den_reg  [QUO_W];
    logic [REM_W-1:0] rem_reg  [QUO_W];
    logic [QUO_W-1:0] quo_reg  [QUO_W];
    side_t            side_reg [QUO_W];
    logic [QUO_W:0]   rdy;

    assign rdy[QUO_W] = out_ready;

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        localparam int unsigned SH = QUO_W - 1 - k;
        logic             src_v;
        logic [DEN_W-1:0] src_den;
        logic [REM_W-1:0] src_rem;
        logic [QUO_W-1:0] src_quo;
        side_t            src_side;
        logic [REM_W-1:0] dsh;
        logic             take;

        if (k == 0)
        begin : g_head
            assign src_v    = in_valid;
            assign src_den  = in_den;
            assign src_rem  = in_rem;
            assign src_quo  = '0;
            assign src_side = in_side;
        end
        else
        begin : g_body
            assign src_v    = v_reg[k-1];
            assign src_den  = den_reg[k-1];
            assign src_rem  = rem_reg[k-1];
            assign src_quo  = quo_reg[k-1];
            assign src_side = side_reg[k-1];
        end

        // Stage k settles one quotient bit.
        assign dsh    = REM_W'(src_den) << SH;
        assign take   = src_rem >= dsh;
        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (rdy[k])
                v_reg[k] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k])
            begin
                den_reg[k]  <= src_den;
                rem_reg[k]  <= take ? (src_rem - dsh) : src_rem;
                quo_reg[k]  <= src_quo | (take ? (QUO_W'(1) << SH) : '0);
                side_reg[k] <= src_side;
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[QUO_W-1];
    assign out_quo   = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule

// ===== rtl/npec_checker.sv =====
// Port-level assertions for the near-plane edge clipper, bound to the top level.
// Depends on npec_pkg and near_plane_edge_clipper_core.
module npec_checker
    import npec_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   cfg_valid,
    input logic                   cfg_ready
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // A degenerate edge reports a zero fraction and no saturation.
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[176] |-> (m_tdata[111:96] == 16'd0) && !m_tdata[177])
        else $error("degenerate edge with non-zero fraction");

    // A saturated fraction sits at one of the two ends.
    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[177] |->
            (m_tdata[111:96] == 16'd0) || (m_tdata[111:96] == 16'd32768))
        else $error("saturated fraction not at an end");

    // A register write holds off edges while the forward vector settles.
    a_settle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("edge accepted right after a register write");

endmodule

bind near_plane_edge_clipper_core npec_checker u_npec_checker (.*);

// ===== bench/tb_near_plane_edge_clipper_core.sv =====
// Self-checking bench for the near-plane edge clipper core: directed table, then random edges.
// Depends on npec_pkg and near_plane_edge_clipper_core; its predictor is written from scratch.
`timescale 1ns / 100ps

module tb_near_plane_edge_clipper_core;
    import npec_pkg::*;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned DRAIN_WAIT  = 30;
    localparam int unsigned LONG_HOLD   = 200;
    localparam int unsigned N_PHASES    = 8;
    localparam int unsigned PHASE_ITEMS = 210;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] bz;
    } edge_t;

    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic signed [31:0] cz;
        logic [15:0]        frac;
        logic signed [31:0] hd;
        logic signed [31:0] sd;
        logic               degen;
        logic               oos;
    } cut_t;

    typedef struct {
        edge_t e;
        bit    typed;
        cut_t  r;
    } row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Register shadow used by the predictor.
    logic [31:0] eye_x_q, eye_y_q, eye_z_q;
    logic [14:0] yaw_q;
    logic [13:0] pitch_q;
    logic [30:0] near_q;

    cut_t        pending_cuts[$];
    int unsigned mismatches;
    int unsigned edges_sent;
    int unsigned cuts_seen;
    int unsigned degen_seen;
    int unsigned span_seen;
    int unsigned idle_cycles;
    bit          calm;
    bit          hold_req;

    near_plane_edge_clipper_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Sine of a quarter-turn angle as Q1.15, Horner evaluation of the Taylor series.
    function automatic longint quarter_sin(longint r);
        longint unsigned one;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned p;
        longint unsigned q;
        one = 64'd1 << TRIG_BITS_DEF;
        x   = (longint'(r) * RAD_SCALE + (64'd1 << (39 - TRIG_BITS_DEF))) >> (40 - TRIG_BITS_DEF);
        x2  = (x * x) >> TRIG_BITS_DEF;
        p   = one - x2 / 110;
        p   = one - ((x2 * p) >> TRIG_BITS_DEF) / 72;
        p   = one - ((x2 * p) >> TRIG_BITS_DEF) / 42;
        p   = one - ((x2 * p) >> TRIG_BITS_DEF) / 20;
        p   = one - ((x2 * p) >> TRIG_BITS_DEF) / 6;
        q   = (x * p) >> TRIG_BITS_DEF;
        q   = (q * 32768 + (one >> 1)) >> TRIG_BITS_DEF;
        if (q > 32768)
            q = 32768;
        return longint'(q);
    endfunction

    // Sine and cosine of any angle in 1/64 degree units, by quadrant symmetry.
    function automatic void angle_sin_cos(longint angle, output longint s, output longint c);
        longint a;
        longint r;
        longint sr;
        longint cr;
        a = angle % longint'(TURN);
        if (a < 0)
            a += longint'(TURN);
        r  = a % longint'(QUARTER);
        sr = quarter_sin(r);
        cr = quarter_sin(longint'(QUARTER) - r);
        case (a / longint'(QUARTER))
            0:       begin s = sr;  c = cr;  end
            1:       begin s = cr;  c = -sr; end
            2:       begin s = -sr; c = -cr; end
            default: begin s = -cr; c = sr;  end
        endcase
    endfunction

    function automatic logic [31:0] clamp32(longint v);
        if (v > 64'sh7FFFFFFF)
            return 32'h7FFFFFFF;
        if (v < -64'sh80000000)
            return 32'h80000000;
        return v[31:0];
    endfunction

    // Works out the cut point, fraction, depths and flags of one edge.
    function automatic cut_t clip_edge(edge_t e);
        cut_t   r;
        longint a[3];
        longint b[3];
        longint eye[3];
        longint fw[3];
        longint sy, cy, sp, cp;
        longint da, db, num, den, u, off;
        a[0] = longint'(e.ax);  a[1] = longint'(e.ay);  a[2] = longint'(e.az);
        b[0] = longint'(e.bx);  b[1] = longint'(e.by);  b[2] = longint'(e.bz);
        eye[0] = longint'($signed(eye_x_q));
        eye[1] = longint'($signed(eye_y_q));
        eye[2] = longint'($signed(eye_z_q));
        angle_sin_cos(longint'(yaw_q), sy, cy);
        angle_sin_cos(longint'($signed(pitch_q)), sp, cp);
        fw[0] = (-(sy * cp) + 16384) >>> 15;
        fw[1] = (cy * cp + 16384) >>> 15;
        fw[2] = sp;
        da = 0;
        db = 0;
        for (int i = 0; i < 3; i++)
        begin
            da += (a[i] - eye[i]) * fw[i];
            db += (b[i] - eye[i]) * fw[i];
        end
        da  = (da + 16384) >>> 15;
        db  = (db + 16384) >>> 15;
        num = da - longint'(near_q);
        den = da - db;
        u   = 0;
        r   = '0;
        if (den == 0)
        begin
            r.degen = 1'b1;
        end
        else
        begin
            if (den < 0)
            begin
                den = -den;
                num = -num;
            end
            if (num < 0)
            begin
                r.oos = 1'b1;
            end
            else if (num > den)
            begin
                r.oos = 1'b1;
                u     = 32768;
            end
            else
            begin
                u = (num * 32768 + den / 2) / den;
                if (u > 32768)
                    u = 32768;
            end
        end
        off  = ((b[0] - a[0]) * u + 16384) >>> 15;
        r.cx = 32'(a[0] + off);
        off  = ((b[1] - a[1]) * u + 16384) >>> 15;
        r.cy = 32'(a[1] + off);
        off  = ((b[2] - a[2]) * u + 16384) >>> 15;
        r.cz = 32'(a[2] + off);
        r.frac = u[15:0];
        r.hd   = clamp32(da);
        r.sd   = clamp32(db);
        return r;
    endfunction

    function automatic logic [31:0] pick_coord(logic [31:0] base, bit wide);
        case ($urandom_range(0, 9))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return $urandom();
            default: return wide ? $urandom() : base + 32'($signed($urandom_range(0, 8388607)) - 4194304);
        endcase
    endfunction

    // Random edge: mostly short edges near the eye so the plane is crossed often.
    function automatic edge_t random_edge();
        edge_t e;
        int    kind;
        kind = $urandom_range(0, 9);
        e.ax = pick_coord(eye_x_q, kind == 6);
        e.ay = pick_coord(eye_y_q, kind == 6);
        e.az = pick_coord(eye_z_q, kind == 6);
        e.bx = pick_coord(eye_x_q, kind == 6);
        e.by = pick_coord(eye_y_q, kind == 6);
        e.bz = pick_coord(eye_z_q, kind == 6);
        if (kind == 7)
        begin
            e.bx = e.ax;
            e.by = e.ay;
            e.bz = e.az;
        end
        else if (kind == 8)
        begin
            e.bx = e.ax + 32'($urandom_range(0, 255));
            e.by = e.ay - 32'($urandom_range(0, 255));
            e.bz = e.az;
        end
        return e;
    endfunction

    function automatic int unsigned gap_len();
        if (calm || $urandom_range(0, 9) < 6)
            return 0;
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(20, 60);
        return $urandom_range(1, 3);
    endfunction

    // Presents one edge and waits for its transfer; the expectation is queued on transfer.
    task automatic send_edge(edge_t e, bit typed, cut_t r);
        int unsigned gap;
        gap = gap_len();
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {e.bz, e.by, e.bx, e.az, e.ay, e.ax};
        do
            @(posedge clk);
        while (!s_tready);
        pending_cuts = {pending_cuts, typed ? r : clip_edge(e)};
        edges_sent++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Waits for the pipeline to empty, then performs one register write.
    task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
        wait (pending_cuts.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_EYE_X: eye_x_q = value;
            REG_EYE_Y: eye_y_q = value;
            REG_EYE_Z: eye_z_q = value;
            REG_YAW:   yaw_q   = value[14:0];
            REG_PITCH: pitch_q = value[13:0];
            REG_NEAR:  near_q  = value[30:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(logic [31:0] ex, logic [31:0] ey, logic [31:0] ez,
                             logic [31:0] yaw, logic [31:0] pitch, logic [31:0] near);
        write_reg(REG_EYE_X, ex);
        write_reg(REG_EYE_Y, ey);
        write_reg(REG_EYE_Z, ez);
        write_reg(REG_YAW, yaw);
        write_reg(REG_PITCH, pitch);
        write_reg(REG_NEAR, near);
    endtask

    function automatic row_t mk_row(logic [31:0] ax, logic [31:0] ay, logic [31:0] az,
                                    logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                    bit typed);
        row_t w;
        w.e     = {ax, ay, az, bx, by, bz};
        w.typed = typed;
        w.r     = '0;
        if (typed)
        begin
            // Both depths are zero here, so the hidden endpoint comes straight back.
            w.r.cx    = ax;
            w.r.cy    = ay;
            w.r.cz    = az;
            w.r.degen = 1'b1;
        end
        return w;
    endfunction

    // Main stimulus sequence.
    initial
    begin
        row_t  rows[$];
        cut_t  none;
        none        = '0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_EYE_X;
        cfg_data    = '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        mismatches  = 0;
        edges_sent  = 0;
        cuts_seen   = 0;
        degen_seen  = 0;
        span_seen   = 0;
        eye_x_q     = '0;
        eye_y_q     = '0;
        eye_z_q     = '0;
        yaw_q       = '0;
        pitch_q     = '0;
        near_q      = 31'd16384;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        // Directed rows under the reset setting: the view looks along +y.
        rows = {rows, mk_row(0, 0, 0, 0, 0, 0, 1)};
        rows = {rows, mk_row(32'h7FFFFFFF, 0, 32'h80000000, 32'h80000000, 0, 32'h7FFFFFFF, 1)};
        rows = {rows, mk_row(0, 0, 0, 0, 32768, 0, 0)};
        rows = {rows, mk_row(0, 0, 0, 0, -32768, 0, 0)};
        rows = {rows, mk_row(0, 0, 0, 0, 8192, 0, 0)};
        rows = {rows, mk_row(5, 0, 7, -9, 65536, 3, 0)};
        rows = {rows, mk_row(0, 32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0)};
        rows = {rows, mk_row(0, 32'h80000000, 0, 0, 32'h7FFFFFFF, 0, 0)};
        rows = {rows, mk_row(1, 16384, 2, 3, 16384, 4, 0)};
        rows = {rows, mk_row(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                             32'h80000000, 32'h80000000, 32'h80000000, 0)};
        rows = {rows, mk_row(-100, 20000, 100, 100, 10000, -100, 0)};
        rows = {rows, mk_row(0, -5, 0, 32'hFFFF, 100000, 32'hFFFF0000, 0)};
        foreach (rows[i])
            send_edge(rows[i].e, rows[i].typed, rows[i].r);
        drop_valid();

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            case (ph)
                0: write_all(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 23039, 5760, 32'h7FFFFFFF);
                1: write_all(32'h80000000, 32'h80000000, 32'h80000000, 0, -5760, 0);
                2: write_all($urandom_range(0, 65535), $urandom_range(0, 65535), 0,
                             $urandom_range(0, 23039), $urandom_range(0, 5760), 16384);
                default: write_all($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                                   $urandom_range(0, 1048575));
            endcase
            // One phase runs without gaps and with the receiver held off for a while.
            calm     = (ph == 3);
            hold_req = (ph == 3);
            repeat (PHASE_ITEMS)
                send_edge(random_edge(), 1'b0, none);
            drop_valid();
            calm = 1'b0;
        end

        wait (pending_cuts.size() == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Covered %0d edges over %0d register settings: %0d degenerate, %0d saturated.",
                 edges_sent, N_PHASES + 1, degen_seen, span_seen);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Receiver readiness: random stalls, plus one long hold-off on request.
    initial
    begin
        int unsigned stall;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_tready = 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
                m_tready = 1'b1;
            end
            else if (!rst_n || calm || $urandom_range(0, 9) < 7)
            begin
                m_tready = rst_n;
            end
            else
            begin
                stall    = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                        : $urandom_range(1, 3);
                m_tready = 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    // Result check against the oldest expectation.
    always @(posedge clk)
    begin
        cut_t got;
        cut_t want;
        if (m_tvalid && m_tready)
        begin
            got.cx    = m_tdata[31:0];
            got.cy    = m_tdata[63:32];
            got.cz    = m_tdata[95:64];
            got.frac  = m_tdata[111:96];
            got.hd    = m_tdata[143:112];
            got.sd    = m_tdata[175:144];
            got.degen = m_tdata[176];
            got.oos   = m_tdata[177];
            cuts_seen++;
            degen_seen += got.degen;
            span_seen  += got.oos;
            if (pending_cuts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result transfer: %h", got);
            end
            else
            begin
                want = pending_cuts.pop_front();
                if (got.cx !== want.cx || got.cy !== want.cy || got.cz !== want.cz ||
                    got.frac !== want.frac || got.hd !== want.hd || got.sd !== want.sd ||
                    got.degen !== want.degen || got.oos !== want.oos)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("Result %0d wrong: cut %h %h %h frac %h depth %h %h flags %b%b",
                                 cuts_seen, got.cx, got.cy, got.cz, got.frac, got.hd, got.sd,
                                 got.degen, got.oos);
                        $display("  expected:  cut %h %h %h frac %h depth %h %h flags %b%b",
                                 want.cx, want.cy, want.cz, want.frac, want.hd, want.sd,
                                 want.degen, want.oos);
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transfer anywhere.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("Timeout with %0d results outstanding", pending_cuts.size());
            $display("Some tests failed");
            $finish;
        end
    end

endmodule
